// ===== design/sfls_pkg.sv =====
// Package for the first/last substring search block.
// Shared widths, defaults, register indexes and the result word layout.
// No dependencies.
`default_nettype none

package sfls_pkg;

   localparam int BYTE_W = 8;
   localparam int PAT_W  = 64;                 // pattern register, eight bytes
   localparam int LEN_W  = 4;                  // pattern length register
   localparam int IDX_W  = 17;                 // reported start index width
   localparam int SEL_W  = 3;                  // byte select within the pattern register

   localparam int              PATTERN_MAX_DEF = 8;
   localparam longint unsigned TEXT_MAX_DEF    = 64'd65536;

   localparam int CSR_IDX_W = 1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PATTERN_BYTES  = 1'b0,
      CSR_PATTERN_LENGTH = 1'b1
   } csr_index_type;

   // Result word, packed lowest field first when sent out.
   typedef struct packed {
      logic             length_overflow;
      logic [IDX_W-1:0] last_start;
      logic [IDX_W-1:0] first_start;
      logic             found;
   } rsp_type;

   localparam int RSP_BITS   = $bits(rsp_type);
   localparam int RSP_DATA_W = ((RSP_BITS + 7) / 8) * 8;

endpackage

`default_nettype wire

// ===== design/sfls_cell.sv =====
// One compare cell of the search row.
// Holds one history byte, hands it to the next cell and compares its window byte.
// Depends on sfls_pkg.
`default_nettype none

module sfls_cell #(
   parameter int CELL_IDX = 0
) (
   input  wire logic                        clock,
   input  wire logic                        take,
   input  wire logic [sfls_pkg::BYTE_W-1:0] win_in,
   input  wire logic [sfls_pkg::PAT_W-1:0]  pattern_bytes,
   input  wire logic [sfls_pkg::LEN_W-1:0]  len_used,
   input  wire logic                        match_in,
   output logic                             match_out,
   output logic [sfls_pkg::BYTE_W-1:0]      win_out
);
   import sfls_pkg::*;

   logic [BYTE_W-1:0] byte_ff;
   logic [BYTE_W-1:0] byte_in;
   logic              active;
   logic [LEN_W-1:0]  sel_full;
   logic [SEL_W-1:0]  sel;
   logic [BYTE_W-1:0] want;

   // This cell sees window byte CELL_IDX and checks pattern byte len-1-CELL_IDX.
   assign active   = LEN_W'(CELL_IDX) < len_used;
   assign sel_full = len_used - LEN_W'(CELL_IDX) - LEN_W'(1);
   assign sel      = sel_full[SEL_W-1:0];
   assign want     = pattern_bytes[sel*BYTE_W +: BYTE_W];

   assign match_out = match_in & (!active || (win_in == want));

   // advance the history on every searched byte
   assign byte_in = take ? win_in : byte_ff;

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

   assign win_out = byte_ff;

endmodule

`default_nettype wire

// ===== design/substring_first_last_search.sv =====
// Top level of the first/last substring search block.
// Builds the row of sfls_cell compare cells, tracks position and matches, and
// buffers results. Depends on sfls_pkg and sfls_cell.
`default_nettype none

// Streams text bytes and reports, at each end of text, whether the configured
// pattern (up to PATTERN_MAX bytes, csr register 0 = bytes with the first
// character lowest, register 1 = length, values above PATTERN_MAX act as
// PATTERN_MAX) occurs, where the first and last occurrences start, and whether
// the text ran past TEXT_MAX bytes (extra bytes are not searched). An empty
// pattern reports found with first_start 0 and last_start equal to the text
// length. A row of PATTERN_MAX cells holds the recent bytes; every cell compares
// its window byte against one pattern byte in the same cycle, so one input word
// is taken every clock while req_tready is high. The tlast word's result is
// registered in the output slot, or in the skid slot while that one is full and not read.
// The two slots let input keep flowing while a result waits; req_tready drops only
// when both are full. Stream state clears after each end of text; registers are kept.
module substring_first_last_search #(
   parameter int              PATTERN_MAX = sfls_pkg::PATTERN_MAX_DEF,
   parameter longint unsigned TEXT_MAX    = sfls_pkg::TEXT_MAX_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // configuration write channel
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [sfls_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [sfls_pkg::PAT_W-1:0]      csr_data,
   // text input
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [7:0]                      req_tdata,   // [7:0] text_byte
   input  wire logic [0:0]                      req_tuser,   // [0] byte_valid
   input  wire logic                            req_tlast,   // end_of_text
   // results
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // [0] found, [17:1] first_start, [34:18] last_start, [35] length_overflow,
   // [39:36] zero
   output logic [sfls_pkg::RSP_DATA_W-1:0]      rsp_tdata
);
   import sfls_pkg::*;

   localparam int POS_W     = $clog2(TEXT_MAX + 64'd1);
   localparam int POS_EXT_W = (POS_W > IDX_W) ? POS_W : IDX_W;

   // configuration registers
   logic [PAT_W-1:0] pattern_bytes_ff, pattern_bytes_in;
   logic [LEN_W-1:0] pattern_length_ff, pattern_length_in;

   // stream state
   logic [POS_W-1:0] pos_ff, pos_in;
   logic             seen_ff, seen_in;
   logic [IDX_W-1:0] first_ff, first_in;
   logic [IDX_W-1:0] last_ff, last_in;
   logic             ovf_ff, ovf_in;

   // result slots
   logic    out_valid_ff, out_valid_in;
   rsp_type out_ff, out_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type skid_ff, skid_in;

   logic                 accept, take, eot, at_limit, hit, pop;
   logic [LEN_W-1:0]     len_used;
   logic [POS_EXT_W-1:0] pos_ext, start;
   logic [POS_EXT_W:0]   pos_plus1;
   logic [POS_W-1:0]     pos_next;
   logic                 seen_next, ovf_next;
   logic [IDX_W-1:0]     first_next, last_next;
   logic [POS_EXT_W-1:0] pos_next_ext;
   rsp_type              result;

   logic [BYTE_W-1:0]    win   [PATTERN_MAX];
   logic                 match [PATTERN_MAX+1];

   // ---------------- configuration ----------------
   assign csr_ready = 1'b1;

   always_comb begin
      pattern_bytes_in  = pattern_bytes_ff;
      pattern_length_in = pattern_length_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_PATTERN_BYTES:  pattern_bytes_in  = csr_data;
            CSR_PATTERN_LENGTH: pattern_length_in = csr_data[LEN_W-1:0];
            default:            pattern_bytes_in  = pattern_bytes_ff;
         endcase
      end
   end

   // clamp the length to the number of cells
   assign len_used = (pattern_length_ff > LEN_W'(PATTERN_MAX)) ?
                     LEN_W'(PATTERN_MAX) : pattern_length_ff;

   // ---------------- input handshake ----------------
   assign req_tready = !skid_valid_ff;
   assign accept     = req_tvalid && req_tready;
   assign eot        = accept && req_tlast;
   assign at_limit   = (pos_ff == POS_W'(TEXT_MAX));
   // a byte is searched only while the position has room
   assign take       = accept && req_tuser[0] && !at_limit;

   // ---------------- cell row ----------------
   // window byte 0 is the incoming byte, byte j the one taken j words ago
   assign win[0]   = req_tdata;
   assign match[0] = 1'b1;

   for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_cell
      if (j < PATTERN_MAX - 1) begin : g_mid
         sfls_cell #(.CELL_IDX(j)) u_cell (
            .clock         (clock),
            .take          (take),
            .win_in        (win[j]),
            .pattern_bytes (pattern_bytes_ff),
            .len_used      (len_used),
            .match_in      (match[j]),
            .match_out     (match[j+1]),
            .win_out       (win[j+1])
         );
      end else begin : g_end
         sfls_cell #(.CELL_IDX(j)) u_cell (
            .clock         (clock),
            .take          (take),
            .win_in        (win[j]),
            .pattern_bytes (pattern_bytes_ff),
            .len_used      (len_used),
            .match_in      (match[j]),
            .match_out     (match[j+1]),
            .win_out       ()
         );
      end
   end

   // ---------------- position and match tracking ----------------
   assign pos_ext   = POS_EXT_W'(pos_ff);
   assign pos_plus1 = {1'b0, pos_ext} + (POS_EXT_W+1)'(1);
   // the window is full once pos+1 reaches the pattern length
   assign hit   = take && (len_used != '0) &&
                  (pos_plus1 >= (POS_EXT_W+1)'(len_used)) && match[PATTERN_MAX];
   assign start = pos_plus1[POS_EXT_W-1:0] - POS_EXT_W'(len_used);

   always_comb begin
      pos_next   = take ? pos_ff + POS_W'(1) : pos_ff;
      ovf_next   = ovf_ff || (accept && req_tuser[0] && at_limit);
      seen_next  = seen_ff || hit;
      first_next = (hit && !seen_ff) ? start[IDX_W-1:0] : first_ff;
      last_next  = hit ? start[IDX_W-1:0] : last_ff;
   end

   assign pos_next_ext = POS_EXT_W'(pos_next);

   // result for a word with tlast, including that word's own byte
   always_comb begin
      result.length_overflow = ovf_next;
      priority if (len_used == '0) begin
         result.found       = 1'b1;
         result.first_start = '0;
         result.last_start  = pos_next_ext[IDX_W-1:0];
      end else if (seen_next) begin
         result.found       = 1'b1;
         result.first_start = first_next;
         result.last_start  = last_next;
      end else begin
         result.found       = 1'b0;
         result.first_start = '0;
         result.last_start  = '0;
      end
   end

   // clear the stream state after end of text, else advance it
   always_comb begin
      if (eot) begin
         pos_in   = '0;
         seen_in  = 1'b0;
         first_in = '0;
         last_in  = '0;
         ovf_in   = 1'b0;
      end else begin
         pos_in   = pos_next;
         seen_in  = seen_next;
         first_in = first_next;
         last_in  = last_next;
         ovf_in   = ovf_next;
      end
   end

   // ---------------- result slots ----------------
   assign pop = out_valid_ff && rsp_tready;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         // no new result can arrive while the skid slot is full
         if (pop) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (eot) begin
         if (!out_valid_ff || pop) begin
            out_in       = result;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = result;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(out_ff);

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_bytes_ff  <= '0;
         pattern_length_ff <= '0;
         pos_ff            <= '0;
         seen_ff           <= 1'b0;
         first_ff          <= '0;
         last_ff           <= '0;
         ovf_ff            <= 1'b0;
         out_valid_ff      <= 1'b0;
         skid_valid_ff     <= 1'b0;
      end else begin
         pattern_bytes_ff  <= pattern_bytes_in;
         pattern_length_ff <= pattern_length_in;
         pos_ff            <= pos_in;
         seen_ff           <= seen_in;
         first_ff          <= first_in;
         last_ff           <= last_in;
         ovf_ff            <= ovf_in;
         out_valid_ff      <= out_valid_in;
         skid_valid_ff     <= skid_valid_in;
      end
   end

   // payload of the result slots, no reset
   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

endmodule

`default_nettype wire
